>>> design/hlf_pkg.sv
// Shared constants, types and arithmetic helpers for the two-state log-domain forward block.
package hlf_pkg;

  // Fixed formats
  localparam int unsigned SlotsPerDay = 96;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned LseDepth    = 256;
  localparam int unsigned LseIdxW     = $clog2(LseDepth);
  localparam int unsigned LseW        = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned AddrW       = 9;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned InDataW     = 80;
  localparam int unsigned InUserW     = 3;
  localparam int unsigned OutDataW    = 64;

  localparam logic signed [DataW-1:0] NegInf = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] PosMax = 32'sh7fff_ffff;

  // Item kinds carried in tuser bit 0
  typedef enum logic {
    OpLoad = 1'b0,
    OpObs  = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMeanRest    = 3'd0,
    CfgMeanActive  = 3'd1,
    CfgCurvRest    = 3'd2,
    CfgCurvActive  = 3'd3,
    CfgOffRest     = 3'd4,
    CfgOffActive   = 3'd5,
    CfgLogPointMass = 3'd6,
    CfgDetectLimit = 3'd7
  } cfg_idx_e;

  // Stage commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic diff;
    logic sq;
    logic scale;
    logic emit;
    logic sum;
    logic max;
    logic lse;
    logic out;
  } hlf_cmd_t;

  typedef logic [LseW-1:0] lse_tab_t [LseDepth];

  // Saturate a widened sum to 32 bits; anything at or below the floor is minus infinity
  function automatic logic signed [DataW-1:0] sat32(input logic signed [33:0] x);
    if (x <= 34'(NegInf)) begin
      return NegInf;
    end else if (x > 34'(PosMax)) begin
      return PosMax;
    end
    return x[DataW-1:0];
  endfunction

  // Three-term sum; minus infinity absorbs
  function automatic logic signed [DataW-1:0] add3(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b,
                                                   input logic signed [DataW-1:0] c);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b) + 34'(c);
    if (a == NegInf || b == NegInf || c == NegInf) begin
      return NegInf;
    end
    return sat32(s);
  endfunction

  // Shift-subtract division, used only while building the table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // log(1+e) in Q30 via the atanh series
  function automatic logic [63:0] ln1p_q30(input logic [63:0] e);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z    = udiv64(e << 30, (64'd1 << 31) + e);
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int n = 0; n < 14; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      term = (term * z2) >> 30;
    end
    return sum << 1;
  endfunction

  // Correction table log(1+exp(-k/16)) in Q.FracBits
  function automatic lse_tab_t build_lse_tab();
    lse_tab_t    tab;
    logic [63:0] e;
    logic [63:0] l;
    logic [63:0] r;
    e = 64'd1 << 30;
    for (int k = 0; k < LseDepth; k++) begin
      l      = ln1p_q30(e);
      r      = ((l << FracBits) + (64'd1 << 29)) >> 30;
      tab[k] = LseW'(r);
      e      = (e * 64'd1008687095) >> 30;
    end
    return tab;
  endfunction

  localparam lse_tab_t LseTab = build_lse_tab();

endpackage

>>> design/hmm_log_forward_two_state.sv
// Top level of the two-state log-domain forward recursion block.
// An observation beat is accepted in the idle state and is then walked by the
// controller through eight datapath stages (difference, square, curvature
// scaling, emission, path sums, logsumexp max, logsumexp correction, weight
// add) into the output register, with the Gaussian path as two multiplier
// stages deep. A load beat (tuser bit 0 low) is written in the idle state and
// produces no result. A finished result waits in the output register while
// the next beat is accepted; the block stalls in its final stage only if
// that register is still full. The transition table and initial values are
// undefined until loaded; there is no clearing pass after reset. Configuration
// writes are always accepted and must only be made while the block is idle.
module hmm_log_forward_two_state import hlf_pkg::*; #(
  parameter int unsigned SLOTS_PER_DAY = SlotsPerDay
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: obs[31:0], word_addr[40:32], word_value[72:41], zero[79:73]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: op[0], seq_start[1], missing[2]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: alpha_rest[31:0], alpha_active[63:32]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [DataW-1:0]    cfg_data_i
);

  hlf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  hlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_op_i     (s_axis_tuser_i[0]),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  hlf_datapath #(
    .SLOTS_PER_DAY (SLOTS_PER_DAY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

>>> design/hlf_ctrl.sv
// Controller: walks one item through the datapath stages and owns both handshakes.
module hlf_ctrl import hlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  input  logic     s_op_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  output hlf_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDiff  = 9'b000000010,
    StSq    = 9'b000000100,
    StScale = 9'b000001000,
    StEmit  = 9'b000010000,
    StSum   = 9'b000100000,
    StMax   = 9'b001000000,
    StLse   = 9'b010000000,
    StOut   = 9'b100000000
  } hlf_state_e;

  hlf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_beat;

  assign s_tready_o = (state_q == StIdle);
  assign in_beat    = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;

  // Next state and stage commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accept = in_beat && (s_op_i == OpObs);
        cmd_o.load   = in_beat && (s_op_i == OpLoad);
        if (cmd_o.accept) begin
          state_d = StDiff;
        end
      end
      StDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = StSq;
      end
      StSq: begin
        cmd_o.sq = 1'b1;
        state_d  = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StMax;
      end
      StMax: begin
        cmd_o.max = 1'b1;
        state_d   = StLse;
      end
      StLse: begin
        cmd_o.lse = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        // wait here only while the previous result is still held
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/hlf_datapath.sv
// Datapath: config registers, transition memories, emission and logsumexp stages.
module hlf_datapath import hlf_pkg::*; #(
  parameter int unsigned SLOTS_PER_DAY = SlotsPerDay
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hlf_cmd_t            cmd_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [DataW-1:0]    cfg_data_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [InUserW-1:0]  s_tuser_i,
  output logic [OutDataW-1:0] m_tdata_o
);

  localparam int unsigned SlotW     = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
  localparam int unsigned TranWords = 4 * SLOTS_PER_DAY;
  localparam logic [SlotW-1:0] SlotLast  = SlotW'(SLOTS_PER_DAY - 1);
  localparam logic [SlotW-1:0] SlotAfterStart = (SLOTS_PER_DAY > 1) ? SlotW'(1) : '0;

  // Input fields
  logic signed [DataW-1:0] in_obs;
  logic [AddrW-1:0]        in_addr;
  logic signed [DataW-1:0] in_value;
  assign in_obs   = s_tdata_i[31:0];
  assign in_addr  = s_tdata_i[40:32];
  assign in_value = s_tdata_i[72:41];

  // Configuration registers
  logic signed [DataW-1:0] mean_q [2];
  logic [DataW-1:0]        curv_q [2];
  logic signed [DataW-1:0] off_q  [2];
  logic signed [DataW-1:0] lpm_q;
  logic signed [DataW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q[0] <= '0;
      mean_q[1] <= '0;
      curv_q[0] <= 32'd32768;
      curv_q[1] <= 32'd32768;
      off_q[0]  <= '0;
      off_q[1]  <= '0;
      lpm_q     <= '0;
      limit_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgMeanRest:     mean_q[0] <= cfg_data_i;
        CfgMeanActive:   mean_q[1] <= cfg_data_i;
        CfgCurvRest:     curv_q[0] <= cfg_data_i;
        CfgCurvActive:   curv_q[1] <= cfg_data_i;
        CfgOffRest:      off_q[0]  <= cfg_data_i;
        CfgOffActive:    off_q[1]  <= cfg_data_i;
        CfgLogPointMass: lpm_q     <= cfg_data_i;
        CfgDetectLimit:  limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Load word decode
  logic             wr_tran, wr_init0, wr_init1, wr_weight;
  logic [SlotW-1:0] wr_slot;
  logic [1:0]       wr_cell;
  assign wr_tran   = cmd_i.load && (32'(in_addr) < TranWords);
  assign wr_init0  = cmd_i.load && (32'(in_addr) == TranWords);
  assign wr_init1  = cmd_i.load && (32'(in_addr) == TranWords + 1);
  assign wr_weight = cmd_i.load && (32'(in_addr) == TranWords + 2);
  assign wr_slot   = SlotW'(in_addr >> 2);
  assign wr_cell   = in_addr[1:0];

  // Initial log probabilities and sequence weight
  logic signed [DataW-1:0] init_q [2];
  logic signed [DataW-1:0] weight_q;

  always_ff @(posedge clk_i) begin
    if (wr_init0) begin
      init_q[0] <= in_value;
    end
    if (wr_init1) begin
      init_q[1] <= in_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (wr_weight) begin
      weight_q <= in_value;
    end
  end

  // Slot position of the next observation
  logic [SlotW-1:0] slot_q, slot_d;
  logic             seq_q, miss_q;

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.sum) begin
      if (seq_q) begin
        slot_d = SlotAfterStart;
      end else if (slot_q == SlotLast) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + SlotW'(1);
      end
    end
  end

  // Transition memories, one per matrix cell, all read at the current slot
  logic signed [DataW-1:0] tran_rd_q [4];

  for (genvar c = 0; c < 4; c++) begin : g_tran
    logic [DataW-1:0] tran_mem_q [SLOTS_PER_DAY];
    always_ff @(posedge clk_i) begin
      if (wr_tran && (wr_cell == 2'(c))) begin
        tran_mem_q[wr_slot] <= in_value;
      end
      if (cmd_i.diff) begin
        tran_rd_q[c] <= tran_mem_q[slot_q];
      end
    end
  end

  // Item capture
  logic signed [DataW-1:0] obs_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      obs_q  <= in_obs;
      seq_q  <= s_tuser_i[1];
      miss_q <= s_tuser_i[2];
    end
  end

  // Gaussian stages for both states
  logic [DataW-1:0]        absd_q [2];
  logic                    pm_q;
  logic [63:0]             sqp_q  [2];
  logic [63:0]             lo_q   [2];
  logic [47:0]             hi_q   [2];
  logic signed [DataW-1:0] em_q   [2];
  logic signed [DataW-1:0] em_d   [2];
  logic signed [32:0]      diff   [2];
  logic [80:0]             full   [2];

  for (genvar j = 0; j < 2; j++) begin : g_gauss
    assign diff[j] = 33'(obs_q) - 33'(mean_q[j]);
    assign full[j] = {1'b0, hi_q[j], 32'd0} + {17'd0, lo_q[j]};

    always_comb begin
      if (off_q[j] == NegInf || (|full[j][80:48])) begin
        em_d[j] = NegInf;
      end else begin
        em_d[j] = sat32(34'(off_q[j]) - $signed({2'b00, full[j][47:16]}));
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.diff) begin
        absd_q[j] <= diff[j][32] ? DataW'(-diff[j]) : diff[j][DataW-1:0];
      end
      if (cmd_i.sq) begin
        sqp_q[j] <= 64'(absd_q[j]) * 64'(absd_q[j]);
      end
      if (cmd_i.scale) begin
        // sq = sqp >> FracBits, split into low 32 and high 16 bits
        lo_q[j] <= 64'(sqp_q[j][47:16]) * 64'(curv_q[j]);
        hi_q[j] <= 48'(sqp_q[j][63:48]) * 48'(curv_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      pm_q <= (obs_q == limit_q);
    end
    if (cmd_i.emit) begin
      if (miss_q) begin
        em_q[0] <= '0;
        em_q[1] <= '0;
      end else begin
        em_q[0] <= em_d[0];
        em_q[1] <= pm_q ? lpm_q : em_d[1];
      end
    end
  end

  // Path sums into each state; first item of a sequence takes the initial value
  logic signed [DataW-1:0] pa_q [2];
  logic signed [DataW-1:0] sa_q [2];
  logic signed [DataW-1:0] sb_q [2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      if (seq_q) begin
        sa_q[0] <= add3(init_q[0], em_q[0], '0);
        sb_q[0] <= NegInf;
        sa_q[1] <= add3(init_q[1], em_q[1], '0);
        sb_q[1] <= NegInf;
      end else begin
        sa_q[0] <= add3(pa_q[0], tran_rd_q[0], em_q[0]);
        sb_q[0] <= add3(pa_q[1], tran_rd_q[2], em_q[0]);
        sa_q[1] <= add3(pa_q[0], tran_rd_q[1], em_q[1]);
        sb_q[1] <= add3(pa_q[1], tran_rd_q[3], em_q[1]);
      end
    end
  end

  // Logsumexp: max and table index, then correction
  logic signed [DataW-1:0] mx_q   [2];
  logic                    mneg_q [2];
  logic                    nneg_q [2];
  logic                    inr_q  [2];
  logic [LseIdxW-1:0]      idx_q  [2];
  logic signed [DataW-1:0] alpha_d [2];

  for (genvar j = 0; j < 2; j++) begin : g_lse
    logic signed [DataW-1:0] mx, mn;
    logic [32:0]             gap;
    logic [32:0]             gap_sh;
    logic [LseW-1:0]         corr;

    assign mx     = (sa_q[j] > sb_q[j]) ? sa_q[j] : sb_q[j];
    assign mn     = (sa_q[j] > sb_q[j]) ? sb_q[j] : sa_q[j];
    assign gap    = 33'(33'(mx) - 33'(mn));
    assign gap_sh = gap >> (FracBits - 4);
    assign corr   = inr_q[j] ? LseTab[idx_q[j]] : '0;

    always_comb begin
      if (mneg_q[j]) begin
        alpha_d[j] = NegInf;
      end else if (nneg_q[j]) begin
        alpha_d[j] = mx_q[j];
      end else begin
        alpha_d[j] = sat32(34'(mx_q[j]) + $signed({18'd0, corr}));
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.max) begin
        mx_q[j]   <= mx;
        mneg_q[j] <= (mx == NegInf);
        nneg_q[j] <= (mn == NegInf);
        inr_q[j]  <= (gap_sh < 33'(LseDepth));
        idx_q[j]  <= gap_sh[LseIdxW-1:0];
      end
    end
  end

  // Forward state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q[0] <= '0;
      pa_q[1] <= '0;
      slot_q  <= '0;
    end else begin
      slot_q <= slot_d;
      if (cmd_i.lse) begin
        pa_q[0] <= alpha_d[0];
        pa_q[1] <= alpha_d[1];
      end
    end
  end

  // Output register: weighted forward values
  logic [OutDataW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      out_q <= {add3(pa_q[1], weight_q, '0), add3(pa_q[0], weight_q, '0)};
    end
  end
  assign m_tdata_o = out_q;

endmodule

>>> design/hlf_checker.sv
// Port-level checker for the forward block, bound to the top level.
module hlf_sva import hlf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic [InUserW-1:0]  s_axis_tuser_i,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic                cfg_ready_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // A held result keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // A load beat never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpLoad) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result after a load beat");

  // An accepted observation keeps the input not ready at the start of its walk
  a_obs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpObs) |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input accepted while an observation is in flight");

  // An accepted observation does not raise a result early
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[0] == OpObs) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result appeared too early");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind hmm_log_forward_two_state hlf_sva u_hlf_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .cfg_ready_o     (cfg_ready_o)
);

>>> tb/sv/hlf_checker.sv
// Checker for the two-state log-domain forward block: predicts alphas and compares output beats.
module hlf_checker import hlf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [InUserW-1:0]  s_tuser_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [DataW-1:0]    cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TranWords = 4 * SlotsPerDay;
  localparam longint     NegInf64  = -64'sd2147483648;

  // Predictor state
  longint  cfg_q [8];
  longint  trans_q [TranWords];
  longint  init_q [2];
  longint  weight_q;
  longint  alpha_q [2];
  int      slot_q;
  longint  corr_tab [LseDepth];
  logic [63:0] alpha_fifo [$];
  int      fails;

  assign fail_count_o = fails;
  assign pending_o    = alpha_fifo.size();

  function automatic longint clamp(input longint x);
    if (x <= NegInf64) return NegInf64;
    if (x > 64'sd2147483647) return 64'sd2147483647;
    return x;
  endfunction

  function automatic longint sum3(input longint a, input longint b, input longint c);
    if (a == NegInf64 || b == NegInf64 || c == NegInf64) return NegInf64;
    return clamp(a + b + c);
  endfunction

  function automatic logic [63:0] log1p_q30(input logic [63:0] e);
    logic [63:0] z, z2, term, acc;
    z = (e << 30) / ((64'd1 << 31) + e);
    z2 = (z * z) >> 30;
    term = z;
    acc = 0;
    for (int n = 0; n < 14; n++) begin
      acc += term / (2 * n + 1);
      term = (term * z2) >> 30;
    end
    return acc << 1;
  endfunction

  function automatic longint emission(input longint x, input longint mean,
                                      input longint curv, input longint off);
    longint d;
    logic [63:0] mag, sq, pen;
    logic [127:0] prod;
    if (off == NegInf64) return NegInf64;
    d = x - mean;
    mag = d < 0 ? -d : d;
    sq = (mag * mag) >> FracBits;
    prod = 128'(sq) * 128'(curv);
    if (prod[127:64] != 0) pen = 64'd1 << 33;
    else pen = prod[63:0] >> FracBits;
    if (pen > (64'd1 << 33)) pen = 64'd1 << 33;
    return clamp(off - longint'(pen));
  endfunction

  function automatic longint log_add(input longint a, input longint b);
    longint hi, lo;
    logic [63:0] k;
    hi = a > b ? a : b;
    lo = a > b ? b : a;
    if (hi == NegInf64) return NegInf64;
    if (lo == NegInf64) return hi;
    k = 64'(hi - lo) >> (FracBits - 4);
    return clamp(hi + (k < LseDepth ? corr_tab[k] : 0));
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    logic [63:0] e;
    e = 64'd1 << 30;
    for (int k = 0; k < LseDepth; k++) begin
      corr_tab[k] = longint'(((log1p_q30(e) << FracBits) + (64'd1 << 29)) >> 30);
      e = (e * 64'd1008687095) >> 30;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    longint x, e0, e1, a0, a1;
    logic [63:0] want;
    int s;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) cfg_q[i] = 0;
      cfg_q[CfgCurvRest]   = 32768;
      cfg_q[CfgCurvActive] = 32768;
      foreach (trans_q[i]) trans_q[i] = 0;
      init_q[0] = 0; init_q[1] = 0;
      alpha_q[0] = 0; alpha_q[1] = 0;
      weight_q = 0;
      slot_q = 0;
      fails = 0;
      alpha_fifo.delete();
    end else begin
      // Register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == CfgCurvRest || cfg_addr_i == CfgCurvActive)
          cfg_q[cfg_addr_i] = longint'({32'd0, cfg_data_i});
        else
          cfg_q[cfg_addr_i] = sx(cfg_data_i);
      end
      // Input beat
      if (s_tvalid_i && s_tready_i) begin
        if (op_e'(s_tuser_i[0]) == OpLoad) begin
          if (s_tdata_i[40:32] < TranWords) trans_q[s_tdata_i[40:32]] = sx(s_tdata_i[72:41]);
          else if (s_tdata_i[40:32] == TranWords) init_q[0] = sx(s_tdata_i[72:41]);
          else if (s_tdata_i[40:32] == TranWords + 1) init_q[1] = sx(s_tdata_i[72:41]);
          else if (s_tdata_i[40:32] == TranWords + 2) weight_q = sx(s_tdata_i[72:41]);
        end else begin
          x = sx(s_tdata_i[31:0]);
          if (s_tuser_i[2]) begin
            e0 = 0; e1 = 0;
          end else begin
            e0 = emission(x, cfg_q[CfgMeanRest], cfg_q[CfgCurvRest], cfg_q[CfgOffRest]);
            if (x == cfg_q[CfgDetectLimit]) e1 = cfg_q[CfgLogPointMass];
            else e1 = emission(x, cfg_q[CfgMeanActive], cfg_q[CfgCurvActive],
                               cfg_q[CfgOffActive]);
          end
          if (s_tuser_i[1]) begin
            a0 = sum3(init_q[0], e0, 0);
            a1 = sum3(init_q[1], e1, 0);
            slot_q = 1 % SlotsPerDay;
          end else begin
            s = slot_q % SlotsPerDay;
            a0 = log_add(sum3(alpha_q[0], trans_q[4*s], e0),
                         sum3(alpha_q[1], trans_q[4*s+2], e0));
            a1 = log_add(sum3(alpha_q[0], trans_q[4*s+1], e1),
                         sum3(alpha_q[1], trans_q[4*s+3], e1));
            slot_q = (s + 1) % SlotsPerDay;
          end
          alpha_q[0] = a0;
          alpha_q[1] = a1;
          want[31:0]  = 32'(sum3(a0, weight_q, 0));
          want[63:32] = 32'(sum3(a1, weight_q, 0));
          alpha_fifo = {alpha_fifo, want};
        end
      end
      // Output beat
      if (m_tvalid_i && m_tready_i) begin
        if (alpha_fifo.size() == 0) begin
          report_mismatch("unexpected result beat", m_tdata_i[31:0], 32'd0);
        end else begin
          want = alpha_fifo.pop_front();
          if (m_tdata_i[31:0] !== want[31:0])
            report_mismatch("alpha_rest", m_tdata_i[31:0], want[31:0]);
          if (m_tdata_i[63:32] !== want[63:32])
            report_mismatch("alpha_active", m_tdata_i[63:32], want[63:32]);
        end
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Stimulus and verdict for the two-state log-domain forward block.
module testbench import hlf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TranWords = 4 * SlotsPerDay;
  localparam int          IdleLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_addr = '0;
  logic [DataW-1:0]    cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  quiet_cycles = 0;
  int                  beat_no;

  always #5 clk_i = ~clk_i;

  hmm_log_forward_two_state u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data)
  );

  hlf_checker u_checker (
    .clk_i, .rst_ni,
    .s_tdata_i(s_tdata), .s_tuser_i(s_tuser), .s_tvalid_i(s_tvalid), .s_tready_i(s_tready),
    .m_tdata_i(m_tdata), .m_tvalid_i(m_tvalid), .m_tready_i(m_tready),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls at random
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one input beat, with an optional random gap first; valid stays up until the
  // next beat or an idle gap replaces it
  task automatic send_beat(input op_e op, input logic first, input logic miss,
                           input logic [31:0] obs, input logic [8:0] addr,
                           input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tdata  <= {7'd0, value, addr, obs};
    s_tuser  <= {miss, first, op};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_word(input logic [8:0] addr, input logic [31:0] value);
    send_beat(OpLoad, 1'b0, 1'b0, $urandom, addr, value);
  endtask

  task automatic observe(input logic first, input logic miss, input logic [31:0] obs);
    send_beat(OpObs, first, miss, obs, 9'($urandom_range(511)), $urandom);
  endtask

  // Valid is dropped by the caller once the last register is written
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_addr  <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Wait for all results, then let the pipeline drain
  task automatic settle();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // Random log value; sometimes minus infinity or an extreme
  function automatic logic [31:0] log_value();
    case ($urandom_range(9))
      0: return NegInf;
      1: return PosMax;
      2: return $urandom;
      default: return -$urandom_range(32'h0008_0000);
    endcase
  endfunction

  // Observation near the configured means, at times the detect limit
  function automatic logic [31:0] pick_obs(input logic [31:0] limit);
    case ($urandom_range(9))
      0: return limit;
      1: return $urandom;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  task automatic load_tables();
    for (int a = 0; a < TranWords + 3; a++) load_word(a[8:0], log_value());
  endtask

  task automatic random_regs(output logic [31:0] limit);
    logic [31:0] pm;
    write_reg(CfgMeanRest, $urandom_range(32'h0002_0000) - 32'h0001_0000);
    write_reg(CfgMeanActive, $urandom_range(32'h0004_0000));
    write_reg(CfgCurvRest, $urandom_range(4) == 0 ? $urandom : $urandom_range(32'h0004_0000));
    write_reg(CfgCurvActive, $urandom_range(4) == 0 ? $urandom : $urandom_range(32'h0004_0000));
    write_reg(CfgOffRest, $urandom_range(9) == 0 ? NegInf : -$urandom_range(32'h0003_0000));
    write_reg(CfgOffActive, $urandom_range(9) == 0 ? NegInf : -$urandom_range(32'h0003_0000));
    pm = $urandom_range(9) == 0 ? NegInf : -$urandom_range(32'h0003_0000);
    write_reg(CfgLogPointMass, pm);
    limit = $urandom_range(3) == 0 ? $urandom : 32'h0000_0000;
    write_reg(CfgDetectLimit, limit);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] limit;
    int len;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme register values and field extremes
    write_reg(CfgMeanRest, 32'h8000_0000);
    write_reg(CfgMeanActive, 32'h7fff_ffff);
    write_reg(CfgCurvRest, 32'hffff_ffff);
    write_reg(CfgCurvActive, 32'h0000_0000);
    write_reg(CfgOffRest, 32'h7fff_ffff);
    write_reg(CfgOffActive, NegInf);
    write_reg(CfgLogPointMass, 32'h0000_0000);
    write_reg(CfgDetectLimit, 32'h0001_0000);
    cfg_valid <= 1'b0;
    load_tables();
    load_word(9'd387, 32'h1234_5678);           // out-of-range address is ignored
    load_word(9'd511, 32'hffff_ffff);
    observe(1'b1, 1'b0, 32'h0001_0000);        // point mass at the detect limit
    observe(1'b0, 1'b1, 32'h0001_0000);        // missing wins over point mass
    observe(1'b0, 1'b0, 32'h8000_0000);
    observe(1'b0, 1'b0, 32'h7fff_ffff);
    observe(1'b0, 1'b0, 32'h0000_0000);
    observe(1'b1, 1'b1, 32'hffff_ffff);
    load_word(9'd386, NegInf);                 // weight at minus infinity
    observe(1'b0, 1'b0, 32'h0000_0001);
    load_word(9'd386, 32'h7fff_ffff);
    observe(1'b0, 1'b0, 32'h0002_0000);
    load_word(9'd386, 32'h0000_0000);
    observe(1'b1, 1'b0, 32'h0000_8000);
    settle();

    // Random phases with differing flow control
    beat_no = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      random_regs(limit);
      while (beat_no < (ph + 1) * 190) begin
        len = $urandom_range(4) == 0 ? $urandom_range(100, 200) : $urandom_range(1, 20);
        observe($urandom_range(19) != 0, $urandom_range(9) == 0, pick_obs(limit));
        beat_no++;
        for (int i = 1; i < len && beat_no < (ph + 1) * 190; i++) begin
          if ($urandom_range(49) == 0)
            load_word(9'($urandom_range(511)), log_value());
          observe($urandom_range(49) == 0, $urandom_range(9) == 0, pick_obs(limit));
          beat_no++;
        end
      end
      settle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
